// File: sv/cheat_code_interpreter_macros.svh
// assertion macros shared by the cheat code interpreter modules
`ifndef CHEAT_CODE_INTERPRETER_MACROS_SVH
`define CHEAT_CODE_INTERPRETER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled while reset is asserted
`define CCI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cci assertion failed");
// next-cycle implication, disabled while reset is asserted
`define CCI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cci assertion failed");
`else
`define CCI_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CCI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: sv/cci_pkg.sv
// types and codes of the cheat code interpreter
package cci_pkg;

  localparam int COND_STACK_DEPTH_DEF = 32;

  // item commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_CODE  = 2'd1;
  localparam logic [1:0] CMD_REPLY = 2'd2;

  // memory request kinds
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  // access widths
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // result status
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_SKIPPED = 3'd1;
  localparam logic [2:0] ST_WAIT    = 3'd2;
  localparam logic [2:0] ST_HALT    = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  // pending read kinds
  localparam logic [3:0] PK_NONE   = 4'd0;
  localparam logic [3:0] PK_GT     = 4'd1;
  localparam logic [3:0] PK_LT     = 4'd2;
  localparam logic [3:0] PK_EQ     = 4'd3;
  localparam logic [3:0] PK_NE     = 4'd4;
  localparam logic [3:0] PK_LD_OF0 = 4'd5;
  localparam logic [3:0] PK_LD_OF1 = 4'd6;
  localparam logic [3:0] PK_LD0_W  = 4'd7;
  localparam logic [3:0] PK_LD0_H  = 4'd8;
  localparam logic [3:0] PK_LD0_B  = 4'd9;
  localparam logic [3:0] PK_LD1_W  = 4'd10;
  localparam logic [3:0] PK_LD1_H  = 4'd11;
  localparam logic [3:0] PK_LD1_B  = 4'd12;

  // code types (top nibble of the code word)
  localparam logic [3:0] TY_WR32   = 4'h0;
  localparam logic [3:0] TY_WR16   = 4'h1;
  localparam logic [3:0] TY_WR8    = 4'h2;
  localparam logic [3:0] TY_GT     = 4'h3;
  localparam logic [3:0] TY_LT     = 4'h4;
  localparam logic [3:0] TY_EQ     = 4'h5;
  localparam logic [3:0] TY_NE     = 4'h6;
  localparam logic [3:0] TY_LD_OFF = 4'hB;
  localparam logic [3:0] TY_EXT    = 4'hD;

  // extended opcodes (code word with the low byte cleared)
  localparam logic [31:0] OP_CLEAR   = 32'hD200_0000;
  localparam logic [31:0] OP_SET_OFF = 32'hD300_0000;
  localparam logic [31:0] OP_ST_W    = 32'hD600_0000;
  localparam logic [31:0] OP_ST_H    = 32'hD700_0000;
  localparam logic [31:0] OP_ST_B    = 32'hD800_0000;
  localparam logic [31:0] OP_LD_W    = 32'hD900_0000;
  localparam logic [31:0] OP_LD_H    = 32'hDA00_0000;
  localparam logic [31:0] OP_LD_B    = 32'hDB00_0000;
  localparam logic [31:0] OP_ADD_OFF = 32'hDC00_0000;
  localparam logic [31:0] OP_BUTTON  = 32'hDD00_0000;
  localparam logic [31:0] OP_MOVE    = 32'hDF00_0000;

  // move group selectors (low byte of a move code)
  localparam logic [7:0] MG_OFFSET  = 8'd0;
  localparam logic [7:0] MG_DATA    = 8'd1;
  localparam logic [7:0] MG_STORAGE = 8'd2;

  // move subopcodes (operand word of a move code)
  localparam logic [31:0] MV_SEL0  = 32'h0000_0000;
  localparam logic [31:0] MV_SEL1  = 32'h0000_0001;
  localparam logic [31:0] MV_CPY_A = 32'h0001_0000;
  localparam logic [31:0] MV_CPY_B = 32'h0001_0001;
  localparam logic [31:0] MV_XFR_A = 32'h0002_0000;
  localparam logic [31:0] MV_XFR_B = 32'h0002_0001;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] code_word;
    logic [31:0] operand_word;
    logic [31:0] read_data;
    logic [31:0] buttons;
  } item_t;

  typedef struct packed {
    logic [1:0]  mem_op;
    logic [31:0] mem_addr;
    logic [1:0]  mem_size;
    logic [31:0] mem_data;
    logic [2:0]  status;
  } result_t;

endpackage

// File: sv/cci_channels.sv
// valid/ready channel interfaces for code items and results

interface cci_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] code_word;
  logic [31:0] operand_word;
  logic [31:0] read_data;
  logic [31:0] buttons;

  modport source (output valid, output cmd, output code_word, output operand_word,
                  output read_data, output buttons, input ready);
  modport sink (input valid, input cmd, input code_word, input operand_word,
                input read_data, input buttons, output ready);
endinterface

interface cci_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mem_op;
  logic [31:0] mem_addr;
  logic [1:0]  mem_size;
  logic [31:0] mem_data;
  logic [2:0]  status;

  modport source (output valid, output mem_op, output mem_addr, output mem_size,
                  output mem_data, output status, input ready);
  modport sink (input valid, input mem_op, input mem_addr, input mem_size,
                input mem_data, input status, output ready);
endinterface

// File: sv/cci_exec.sv
// execute stage: interpreter state and the per-item decode and update logic
`include "cheat_code_interpreter_macros.svh"

module cci_exec #(
  parameter int COND_STACK_DEPTH = cci_pkg::COND_STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  cci_pkg::item_t  item,
  output cci_pkg::result_t res
);

  localparam int DW = $clog2(COND_STACK_DEPTH + 1);
  localparam int IW = (COND_STACK_DEPTH > 1) ? $clog2(COND_STACK_DEPTH) : 1;
  localparam logic [DW-1:0] DEPTH_MAX = DW'(COND_STACK_DEPTH);

  logic [31:0]                 off_r [2];
  logic [31:0]                 off_nxt [2];
  logic [31:0]                 dat_r [2];
  logic [31:0]                 dat_nxt [2];
  logic [31:0]                 sto_r [2];
  logic [31:0]                 sto_nxt [2];
  logic                        off_sel_r, off_sel_nxt;
  logic                        dat_sel_r, dat_sel_nxt;
  logic                        sto_sel_r, sto_sel_nxt;
  logic [COND_STACK_DEPTH-1:0] stack_r, stack_nxt;
  logic [DW-1:0]               depth_r, depth_nxt;
  logic                        running_r, running_nxt;
  logic [3:0]                  pend_kind_r, pend_kind_nxt;
  logic [31:0]                 pend_imm_r, pend_imm_nxt;

  logic [3:0]    ctype;
  logic [31:0]   base;
  logic [31:0]   off_cur;
  logic [31:0]   op_w;
  logic [7:0]    sub;
  logic          sel;
  logic [1:0]    size;
  logic [31:0]   rd;
  logic [DW-1:0] depth_m1;
  logic          top_false;
  logic          clear_all;
  logic          do_push;
  logic          push_val;
  logic          halt_req;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    case (sz)
      cci_pkg::SIZE_BYTE: size_mask = 32'h0000_00FF;
      cci_pkg::SIZE_HALF: size_mask = 32'h0000_FFFF;
      default:            size_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  assign ctype     = item.code_word[31:28];
  assign base      = {4'h0, item.code_word[27:0]};
  assign off_cur   = off_r[off_sel_r];
  assign op_w      = {item.code_word[31:8], 8'h00};
  assign sub       = item.code_word[7:0];
  assign rd        = item.read_data;
  assign depth_m1  = depth_r - DW'(1);
  assign top_false = (depth_r != '0) && !stack_r[depth_m1[IW-1:0]];
  assign clear_all = (item.code_word == cci_pkg::OP_CLEAR) && (item.operand_word == '0);
  // data register picked by a store or load: zero means the active one
  assign sel       = (sub == 8'd0) ? dat_sel_r : sub[1];

  always_comb begin
    off_nxt       = off_r;
    dat_nxt       = dat_r;
    sto_nxt       = sto_r;
    off_sel_nxt   = off_sel_r;
    dat_sel_nxt   = dat_sel_r;
    sto_sel_nxt   = sto_sel_r;
    stack_nxt     = stack_r;
    depth_nxt     = depth_r;
    running_nxt   = running_r;
    pend_kind_nxt = pend_kind_r;
    pend_imm_nxt  = pend_imm_r;
    res           = '0;
    do_push       = 1'b0;
    push_val      = 1'b0;
    halt_req      = 1'b0;
    size          = cci_pkg::SIZE_WORD;

    if (fire) begin
      case (item.cmd)
        cci_pkg::CMD_START: begin
          off_nxt[0]    = '0;
          off_nxt[1]    = '0;
          dat_nxt[0]    = '0;
          dat_nxt[1]    = '0;
          off_sel_nxt   = 1'b0;
          dat_sel_nxt   = 1'b0;
          stack_nxt     = '0;
          depth_nxt     = '0;
          pend_kind_nxt = cci_pkg::PK_NONE;
          pend_imm_nxt  = '0;
          running_nxt   = 1'b1;
          res.status    = cci_pkg::ST_DONE;
        end

        cci_pkg::CMD_REPLY: begin
          if (!running_r) begin
            res.status = cci_pkg::ST_IGNORED;
          end else begin
            pend_kind_nxt = cci_pkg::PK_NONE;
            res.status    = cci_pkg::ST_DONE;
            case (pend_kind_r)
              cci_pkg::PK_GT: begin
                do_push  = 1'b1;
                push_val = pend_imm_r > rd;
              end
              cci_pkg::PK_LT: begin
                do_push  = 1'b1;
                push_val = pend_imm_r < rd;
              end
              cci_pkg::PK_EQ: begin
                do_push  = 1'b1;
                push_val = pend_imm_r == rd;
              end
              cci_pkg::PK_NE: begin
                do_push  = 1'b1;
                push_val = pend_imm_r != rd;
              end
              cci_pkg::PK_LD_OF0: off_nxt[0] = rd;
              cci_pkg::PK_LD_OF1: off_nxt[1] = rd;
              cci_pkg::PK_LD0_W:  dat_nxt[0] = rd;
              cci_pkg::PK_LD0_H:  dat_nxt[0] = {16'h0000, rd[15:0]};
              cci_pkg::PK_LD0_B:  dat_nxt[0] = {24'h000000, rd[7:0]};
              cci_pkg::PK_LD1_W:  dat_nxt[1] = rd;
              cci_pkg::PK_LD1_H:  dat_nxt[1] = {16'h0000, rd[15:0]};
              cci_pkg::PK_LD1_B:  dat_nxt[1] = {24'h000000, rd[7:0]};
              default: ;
            endcase
          end
        end

        cci_pkg::CMD_CODE: begin
          if (!running_r) begin
            res.status = cci_pkg::ST_IGNORED;
          end else begin
            // a new code drops any read still waiting for its reply
            pend_kind_nxt = cci_pkg::PK_NONE;
            if (top_false && !clear_all) begin
              res.status = cci_pkg::ST_SKIPPED;
            end else begin
              res.status = cci_pkg::ST_DONE;
              case (ctype)
                cci_pkg::TY_WR32, cci_pkg::TY_WR16, cci_pkg::TY_WR8: begin
                  size         = 2'(cci_pkg::SIZE_WORD - ctype[1:0]);
                  res.mem_op   = cci_pkg::MEM_WRITE;
                  res.mem_addr = base + off_cur;
                  res.mem_size = size;
                  res.mem_data = item.operand_word & size_mask(size);
                end
                cci_pkg::TY_GT, cci_pkg::TY_LT, cci_pkg::TY_EQ, cci_pkg::TY_NE: begin
                  pend_kind_nxt = 4'(ctype - 4'd2);
                  pend_imm_nxt  = item.operand_word;
                  res.mem_op    = cci_pkg::MEM_READ;
                  res.mem_addr  = base + off_cur;
                  res.mem_size  = cci_pkg::SIZE_WORD;
                  res.status    = cci_pkg::ST_WAIT;
                end
                cci_pkg::TY_LD_OFF: begin
                  pend_kind_nxt = off_sel_r ? cci_pkg::PK_LD_OF1 : cci_pkg::PK_LD_OF0;
                  res.mem_op    = cci_pkg::MEM_READ;
                  res.mem_addr  = base + off_cur;
                  res.mem_size  = cci_pkg::SIZE_WORD;
                  res.status    = cci_pkg::ST_WAIT;
                end
                cci_pkg::TY_EXT: begin
                  if (op_w == cci_pkg::OP_SET_OFF && sub <= 8'd1) begin
                    off_nxt[sub[0]] = item.operand_word;
                  end else if ((op_w == cci_pkg::OP_ST_W || op_w == cci_pkg::OP_ST_H ||
                                op_w == cci_pkg::OP_ST_B) && sub <= 8'd2) begin
                    size = (op_w == cci_pkg::OP_ST_W) ? cci_pkg::SIZE_WORD :
                           (op_w == cci_pkg::OP_ST_H) ? cci_pkg::SIZE_HALF :
                                                        cci_pkg::SIZE_BYTE;
                    res.mem_op           = cci_pkg::MEM_WRITE;
                    res.mem_addr         = off_cur + item.operand_word;
                    res.mem_size         = size;
                    res.mem_data         = dat_r[sel] & size_mask(size);
                    // post-increment the active offset by the access width
                    off_nxt[off_sel_r]   = off_cur + (32'd1 << size);
                  end else if ((op_w == cci_pkg::OP_LD_W || op_w == cci_pkg::OP_LD_H ||
                                op_w == cci_pkg::OP_LD_B) && sub <= 8'd2) begin
                    size = (op_w == cci_pkg::OP_LD_W) ? cci_pkg::SIZE_WORD :
                           (op_w == cci_pkg::OP_LD_H) ? cci_pkg::SIZE_HALF :
                                                        cci_pkg::SIZE_BYTE;
                    case (size)
                      cci_pkg::SIZE_WORD:
                        pend_kind_nxt = sel ? cci_pkg::PK_LD1_W : cci_pkg::PK_LD0_W;
                      cci_pkg::SIZE_HALF:
                        pend_kind_nxt = sel ? cci_pkg::PK_LD1_H : cci_pkg::PK_LD0_H;
                      default:
                        pend_kind_nxt = sel ? cci_pkg::PK_LD1_B : cci_pkg::PK_LD0_B;
                    endcase
                    res.mem_op   = cci_pkg::MEM_READ;
                    res.mem_addr = item.operand_word + off_cur;
                    res.mem_size = size;
                    res.status   = cci_pkg::ST_WAIT;
                  end else if (item.code_word == cci_pkg::OP_ADD_OFF) begin
                    off_nxt[off_sel_r] = off_cur + item.operand_word;
                  end else if (item.code_word == cci_pkg::OP_BUTTON) begin
                    do_push  = 1'b1;
                    push_val = (item.buttons & item.operand_word) == item.operand_word;
                  end else if (op_w == cci_pkg::OP_MOVE && sub <= 8'd2) begin
                    case (sub)
                      cci_pkg::MG_OFFSET: begin
                        case (item.operand_word)
                          cci_pkg::MV_SEL0:  off_sel_nxt = 1'b0;
                          cci_pkg::MV_SEL1:  off_sel_nxt = 1'b1;
                          cci_pkg::MV_CPY_A: off_nxt[1]  = off_r[0];
                          cci_pkg::MV_CPY_B: off_nxt[0]  = off_r[1];
                          cci_pkg::MV_XFR_A: dat_nxt[0]  = off_r[0];
                          cci_pkg::MV_XFR_B: dat_nxt[1]  = off_r[1];
                          default:           halt_req    = 1'b1;
                        endcase
                      end
                      cci_pkg::MG_DATA: begin
                        case (item.operand_word)
                          cci_pkg::MV_SEL0:  dat_sel_nxt = 1'b0;
                          cci_pkg::MV_SEL1:  dat_sel_nxt = 1'b1;
                          cci_pkg::MV_CPY_A: dat_nxt[1]  = dat_r[0];
                          cci_pkg::MV_CPY_B: dat_nxt[0]  = dat_r[1];
                          cci_pkg::MV_XFR_A: off_nxt[0]  = dat_r[0];
                          cci_pkg::MV_XFR_B: off_nxt[1]  = dat_r[1];
                          default:           halt_req    = 1'b1;
                        endcase
                      end
                      default: begin
                        case (item.operand_word)
                          cci_pkg::MV_SEL0:  sto_sel_nxt = 1'b0;
                          cci_pkg::MV_SEL1:  sto_sel_nxt = 1'b1;
                          cci_pkg::MV_CPY_A: dat_nxt[0]  = sto_r[0];
                          cci_pkg::MV_CPY_B: dat_nxt[1]  = sto_r[1];
                          cci_pkg::MV_XFR_A: sto_nxt[0]  = dat_r[0];
                          cci_pkg::MV_XFR_B: sto_nxt[1]  = dat_r[1];
                          default:           halt_req    = 1'b1;
                        endcase
                      end
                    endcase
                  end else if (clear_all) begin
                    depth_nxt = '0;
                  end else begin
                    halt_req = 1'b1;
                  end
                end
                default: halt_req = 1'b1;
              endcase
            end
          end
        end

        default: res.status = cci_pkg::ST_DONE;
      endcase

      // condition push, halting on a full stack
      if (do_push) begin
        if (depth_r >= DEPTH_MAX) begin
          halt_req = 1'b1;
        end else begin
          stack_nxt[depth_r[IW-1:0]] = push_val;
          depth_nxt                  = depth_r + DW'(1);
        end
      end

      if (halt_req) begin
        running_nxt   = 1'b0;
        pend_kind_nxt = cci_pkg::PK_NONE;
        res           = '0;
        res.status    = cci_pkg::ST_HALT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r[0]    <= '0;
      off_r[1]    <= '0;
      dat_r[0]    <= '0;
      dat_r[1]    <= '0;
      sto_r[0]    <= '0;
      sto_r[1]    <= '0;
      off_sel_r   <= 1'b0;
      dat_sel_r   <= 1'b0;
      sto_sel_r   <= 1'b0;
      stack_r     <= '0;
      depth_r     <= '0;
      running_r   <= 1'b0;
      pend_kind_r <= cci_pkg::PK_NONE;
      pend_imm_r  <= '0;
    end else begin
      off_r       <= off_nxt;
      dat_r       <= dat_nxt;
      sto_r       <= sto_nxt;
      off_sel_r   <= off_sel_nxt;
      dat_sel_r   <= dat_sel_nxt;
      sto_sel_r   <= sto_sel_nxt;
      stack_r     <= stack_nxt;
      depth_r     <= depth_nxt;
      running_r   <= running_nxt;
      pend_kind_r <= pend_kind_nxt;
      pend_imm_r  <= pend_imm_nxt;
    end
  end

  `CCI_ASSERT_IMPL(a_halted_no_pend, clk, rst_n, !running_r, pend_kind_r == cci_pkg::PK_NONE)
  `CCI_ASSERT_IMPL(a_depth_bound, clk, rst_n, 1'b1, depth_r <= DEPTH_MAX)
  `CCI_ASSERT_NEXT(a_halt_stops, clk, rst_n, fire && res.status == cci_pkg::ST_HALT, !running_r)
  `CCI_ASSERT_NEXT(a_wait_pends, clk, rst_n, fire && res.status == cci_pkg::ST_WAIT, pend_kind_r != cci_pkg::PK_NONE)

endmodule

// File: sv/cheat_code_interpreter.sv
// Cheat code interpreter top level. Takes items (start, code pair or read reply) and
// gives exactly one result per item. An accepted item lands in an input register, is
// executed by the execute stage once the output register can take its result, and its
// result sits in the output register; the sustained rate is one item per clock cycle
// while the output is taken, set by the execute stage, where each item reads and
// updates the offset, data, storage and condition stack registers. Both channels are
// valid/ready; a result waiting in the output register does not block a new input
// transfer while the input register is free, and the input register drains into the
// output register in the same cycle the output is taken. A read request (status waiting
// read) completes on the next read reply item, unless a code or start item drops it.
// COND_STACK_DEPTH sets how deep conditions may nest before a push halts the block.
`include "cheat_code_interpreter_macros.svh"

module cheat_code_interpreter #(
  parameter int COND_STACK_DEPTH = cci_pkg::COND_STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cci_in_if.sink    in_if,
  cci_out_if.source out_if
);

  // input register
  logic             in_vld_r, in_vld_nxt;
  cci_pkg::item_t   in_item_r;

  // output register
  logic             out_vld_r, out_vld_nxt;
  cci_pkg::result_t out_res_r;

  cci_pkg::result_t exec_res;
  logic             exec_fire;
  logic             in_take;

  // execute when an item is held and the output register can take its result
  assign exec_fire   = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || exec_fire;
  assign in_take     = in_if.valid && in_if.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (exec_fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (exec_fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers load on their transfer, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.cmd          <= in_if.cmd;
      in_item_r.code_word    <= in_if.code_word;
      in_item_r.operand_word <= in_if.operand_word;
      in_item_r.read_data    <= in_if.read_data;
      in_item_r.buttons      <= in_if.buttons;
    end
    if (exec_fire) begin
      out_res_r <= exec_res;
    end
  end

  // interpreter state and per-item decode
  cci_exec #(
    .COND_STACK_DEPTH(COND_STACK_DEPTH)
  ) u_exec (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (exec_fire),
    .item (in_item_r),
    .res  (exec_res)
  );

  assign out_if.valid    = out_vld_r;
  assign out_if.mem_op   = out_res_r.mem_op;
  assign out_if.mem_addr = out_res_r.mem_addr;
  assign out_if.mem_size = out_res_r.mem_size;
  assign out_if.mem_data = out_res_r.mem_data;
  assign out_if.status   = out_res_r.status;

  // back pressure only when both stages are full and the result is not taken
  `CCI_ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_if.ready, in_vld_r && out_vld_r && !out_if.ready)

endmodule
